FILE: design/tnsi_pkg.sv
// Shared constants for the top-N sorted insertion list.
// Field widths and stream packing; used by every design file.
package tnsi_pkg;

   localparam int SCORE_BITS    = 31;
   localparam int IN_TAG_BITS   = 32;
   localparam int OUT_TAG_BITS  = 32;
   localparam int RANK_BITS     = 4;
   localparam int WIDE_TAG_BITS = 64;

   // request tdata: score, name tag, one pad bit
   localparam int REQ_DATA_BITS = 64;
   localparam int REQ_TAG_LSB   = SCORE_BITS;

   // response tdata: rank, score, tag, five pad bits
   localparam int RSP_DATA_BITS = 72;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RANK_BITS - SCORE_BITS - OUT_TAG_BITS;

endpackage

FILE: design/top_n_sorted_insert.sv
// Top-N sorted insertion list: keeps the LIST_SIZE best (score, tag) entries.
// A rejected offer gives no item. A taken offer is accepted, then the list
// memory is walked once, one rank per cycle while the output is not stalled,
// through its one read port and one write port; rank 0 leaves first. Reset
// is synchronous: the list reads as all zero right after reset (valid bits
// cleared at once, no clearing pass).
module top_n_sorted_insert #(
   parameter int LIST_SIZE = 10,
   parameter int TAG_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: offered_score [30:0], name_tag [62:31], zero [63]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tnsi_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // rsp_tdata: rank [3:0], kept_score [34:4], kept_tag [66:35], zero [71:67]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tnsi_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // rsp_tlast: last_of_list
   output logic                                rsp_tlast
);

   localparam int IW = $clog2(LIST_SIZE);
   localparam int CW = $clog2(LIST_SIZE + 1);
   localparam int SB = tnsi_pkg::SCORE_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic          state_ff, state_in;
   logic [SB-1:0] lowest_ff, lowest_in;       // copy of the last rank's score
   logic [SB-1:0] off_score_ff, off_score_in;
   logic [TAG_BITS-1:0] off_tag_ff, off_tag_in;
   logic [CW-1:0] iss_idx_ff, iss_idx_in;     // next rank to read
   logic          d_vld_ff, d_vld_in;         // read data present
   logic [IW-1:0] d_idx_ff, d_idx_in;         // rank of the read data
   logic          ins_ff, ins_in;             // offer already placed
   logic [SB-1:0] car_score_ff, car_score_in; // entry pushed down one rank
   logic [TAG_BITS-1:0] car_tag_ff, car_tag_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [tnsi_pkg::RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tlast_ff, rsp_tlast_in;

   logic          rd_en;
   logic [SB-1:0] rd_score;
   logic [TAG_BITS-1:0] rd_tag;
   logic          wr_en;
   logic [SB-1:0] wr_score;
   logic [TAG_BITS-1:0] wr_tag;

   logic          advance, accept, proc, last_rank;
   logic [SB-1:0] req_score;
   logic [tnsi_pkg::WIDE_TAG_BITS-1:0] req_tag_wide, out_tag_wide;
   logic [7:0]    rank_wide;

   tnsi_list_ram #(
      .DEPTH    (LIST_SIZE),
      .TAG_BITS (TAG_BITS)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (iss_idx_ff[IW-1:0]),
      .rd_score (rd_score),
      .rd_tag   (rd_tag),
      .wr_en    (wr_en),
      .wr_addr  (d_idx_ff),
      .wr_score (wr_score),
      .wr_tag   (wr_tag)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_score  = req_tdata[SB-1:0];
   assign req_tag_wide = tnsi_pkg::WIDE_TAG_BITS'(
      req_tdata[tnsi_pkg::REQ_TAG_LSB +: tnsi_pkg::IN_TAG_BITS]);

   // the output register frees up when empty or being taken
   assign advance   = !rsp_tvalid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   assign proc      = (state_ff == ST_WALK) && advance && d_vld_ff;
   assign last_rank = (d_idx_ff == IW'(LIST_SIZE - 1));

   always_comb begin
      state_in      = state_ff;
      lowest_in     = lowest_ff;
      off_score_in  = off_score_ff;
      off_tag_in    = off_tag_ff;
      iss_idx_in    = iss_idx_ff;
      d_vld_in      = d_vld_ff;
      d_idx_in      = d_idx_ff;
      ins_in        = ins_ff;
      car_score_in  = car_score_ff;
      car_tag_in    = car_tag_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_score      = rd_score;
      wr_tag        = rd_tag;

      // take the offer only if it beats the lowest kept score
      if (accept && (lowest_ff < req_score)) begin
         state_in     = ST_WALK;
         off_score_in = req_score;
         off_tag_in   = req_tag_wide[TAG_BITS-1:0];
         iss_idx_in   = '0;
         d_vld_in     = 1'b0;
         ins_in       = 1'b0;
      end

      if ((state_ff == ST_WALK) && advance) begin
         // issue the read of the next rank; it never collides with the write
         if (iss_idx_ff < CW'(LIST_SIZE)) begin
            rd_en      = 1'b1;
            d_vld_in   = 1'b1;
            d_idx_in   = iss_idx_ff[IW-1:0];
            iss_idx_in = iss_idx_ff + CW'(1);
         end else begin
            d_vld_in = 1'b0;
         end
      end

      if (proc) begin
         // stable placement: first rank whose score is strictly lower
         if (!ins_ff && (rd_score < off_score_ff)) begin
            wr_en        = 1'b1;
            wr_score     = off_score_ff;
            wr_tag       = off_tag_ff;
            ins_in       = 1'b1;
            car_score_in = rd_score;
            car_tag_in   = rd_tag;
         end else if (ins_ff) begin
            // shift down: write the entry from the rank above
            wr_en        = 1'b1;
            wr_score     = car_score_ff;
            wr_tag       = car_tag_ff;
            car_score_in = rd_score;
            car_tag_in   = rd_tag;
         end
         if (last_rank) begin
            lowest_in = wr_score;
            state_in  = ST_IDLE;
         end
      end

      if (advance) begin
         rsp_tvalid_in = proc;
         if (proc) begin
            rsp_tdata_in = {{tnsi_pkg::RSP_PAD_BITS{1'b0}},
                            out_tag_wide[tnsi_pkg::OUT_TAG_BITS-1:0],
                            wr_score,
                            rank_wide[tnsi_pkg::RANK_BITS-1:0]};
            rsp_tlast_in = last_rank;
         end
      end
   end

   // rank wraps at 16, tags cut to 32 bits on the way out
   assign rank_wide    = 8'(d_idx_ff);
   assign out_tag_wide = tnsi_pkg::WIDE_TAG_BITS'(wr_tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lowest_ff     <= '0;
         iss_idx_ff    <= '0;
         d_vld_ff      <= 1'b0;
         ins_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lowest_ff     <= lowest_in;
         iss_idx_ff    <= iss_idx_in;
         d_vld_ff      <= d_vld_in;
         ins_ff        <= ins_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_score_ff <= off_score_in;
      off_tag_ff   <= off_tag_in;
      d_idx_ff     <= d_idx_in;
      car_score_ff <= car_score_in;
      car_tag_ff   <= car_tag_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

FILE: design/tnsi_list_ram.sv
// List storage: one entry per rank, score and tag, synchronous read.
// Per-entry valid bits make never-written entries read as zero.
// Depends on tnsi_pkg.
module tnsi_list_ram #(
   parameter int DEPTH    = 10,
   parameter int TAG_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [tnsi_pkg::SCORE_BITS-1:0]  rd_score,
   output logic [TAG_BITS-1:0]              rd_tag,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [tnsi_pkg::SCORE_BITS-1:0]  wr_score,
   input  logic [TAG_BITS-1:0]              wr_tag
);

   localparam int ENTRY_BITS = tnsi_pkg::SCORE_BITS + TAG_BITS;

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [ENTRY_BITS-1:0] rdata_ff;
   logic                  rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_tag, wr_score};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as a cleared slot
   assign rd_score = rvalid_ff ? rdata_ff[tnsi_pkg::SCORE_BITS-1:0] : '0;
   assign rd_tag   = rvalid_ff ? rdata_ff[ENTRY_BITS-1:tnsi_pkg::SCORE_BITS] : '0;

endmodule

FILE: design/tnsi_checker.sv
// Port-level checks for the top-N sorted insertion list, with its bind.
// Depends on tnsi_pkg and top_n_sorted_insert.
module tnsi_checker #(
   parameter int LIST_SIZE = 10
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [tnsi_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tnsi_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                rsp_tlast
);

   localparam int LAST_RANK = (LIST_SIZE - 1) % 16;

   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response item changed");

   // the list closes on its last rank
   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tdata[tnsi_pkg::RANK_BITS-1:0] == tnsi_pkg::RANK_BITS'(LAST_RANK))
      else $error("last item not at the final rank");

   // no new offer while a rank before the last one is still waiting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("offer taken in the middle of a list");

   // a zero score is always rejected
   a_zero_reject: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[tnsi_pkg::SCORE_BITS-1:0] == '0)
         |=> req_tready)
      else $error("zero score offer started a list");

endmodule

bind top_n_sorted_insert tnsi_checker #(.LIST_SIZE(LIST_SIZE)) u_tnsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
